### hdl/ottb_pkg.sv
// Package for the ordered timeout timer bank.
// Holds sizes, command and result codes, beat structs and control structs.
// No dependencies.
`timescale 1ns / 1ps

package ottb_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int IDX_W = $clog2(NUM_TIMERS);

	localparam logic [31:0] HALF_RANGE = 32'h7FFF_FFFF;
	localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

	// Command codes.
	localparam logic [2:0] CMD_TICK     = 3'd0;
	localparam logic [2:0] CMD_INIT     = 3'd1;
	localparam logic [2:0] CMD_START    = 3'd2;
	localparam logic [2:0] CMD_STOP     = 3'd3;
	localparam logic [2:0] CMD_GET      = 3'd4;
	localparam logic [2:0] CMD_SET      = 3'd5;
	localparam logic [2:0] CMD_ONESHOT  = 3'd6;
	localparam logic [2:0] CMD_PERIODIC = 3'd7;

	// Result kinds and status codes.
	localparam logic KIND_ACK = 1'b0;
	localparam logic KIND_EXPIRED = 1'b1;
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef struct packed {
		logic [2:0]  command;
		logic [3:0]  timer_id;
		logic [31:0] period_value;
		logic        periodic_mode;
	} in_beat_t;

	typedef struct packed {
		logic        result_kind;
		logic [3:0]  result_timer;
		logic        status;
		logic [30:0] period_read;
		logic        last_result;
	} out_beat_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic accept;    // take an input beat and apply it
		logic push_ack;  // move the staged acknowledge to the output
		logic scan_step; // evaluate one slot in the scan
		logic fire;      // expire the best slot and restart the scan
		logic finish;    // emit the pending expiry as the last result
	} ctl_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic is_tick;
		logic scan_last;
		logic best_expired;
		logic pending;
		logic out_free;
	} ctl_stat_t;

endpackage

### hdl/ordered_timeout_timer_bank_unit.sv
// Ordered timeout timer bank, top level.
// A non-tick command is acknowledged from the ACK state once the output is free.
// A tick makes one scan pass over all slots per expired timer, plus one more;
// the scan evaluates one slot per cycle, and an expiry beat is pushed only when the output is free.
// Asynchronous active-low reset clears all timers, counters and the tick count.
`timescale 1ns / 1ps

module ordered_timeout_timer_bank_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ottb_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ottb_pkg::out_beat_t out_data
);
	import ottb_pkg::*;

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	// Sequencer.
	ottb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Timer state and result path.
	ottb_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### hdl/ottb_datapath.sv
// Datapath of the ordered timeout timer bank: timer state, slot scan,
// best-candidate registers and the output register. Depends on ottb_pkg.
`timescale 1ns / 1ps

module ottb_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  ottb_pkg::in_beat_t  in_data,
	input  ottb_pkg::ctl_cmd_t  cmd,
	output ottb_pkg::ctl_stat_t stat,
	output logic                out_valid,
	input  logic                out_ready,
	output ottb_pkg::out_beat_t out_data
);
	import ottb_pkg::*;

	logic [31:0]       tick_now_q;
	logic [31:0]       start_counter_q;
	logic [31:0]       deadline_q [NUM_TIMERS];
	logic [30:0]       period_q [NUM_TIMERS];
	logic [31:0]       order_q [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] active_q;
	logic [NUM_TIMERS-1:0] periodic_q;
	logic [NUM_TIMERS-1:0] fired_q;

	logic [IDX_W-1:0]  idx_q;
	logic              best_valid_q;
	logic [IDX_W-1:0]  best_id_q;
	logic [31:0]       best_key_q;
	logic [31:0]       best_dl_q;
	logic [30:0]       best_period_q;
	logic              best_periodic_q;
	logic [31:0]       best_order_q;

	logic              pend_valid_q;
	logic [IDX_W-1:0]  pend_id_q;
	out_beat_t         ack_q;
	logic              out_valid_q;
	out_beat_t         out_q;

	logic [IDX_W-1:0]  rd;
	logic [31:0]       key;
	logic [31:0]       order_gap;
	logic              cand;
	logic              better;
	logic [30:0]       sat;
	logic [30:0]       arm_p;
	logic [30:0]       rearm_p;
	logic              out_free;

	// Slot read address: scan index during a tick, addressed slot otherwise.
	assign rd = cmd.scan_step ? idx_q : in_data.timer_id[IDX_W-1:0];

	// Compare the scanned slot against the best candidate so far.
	always_comb begin
		key = (deadline_q[rd] - tick_now_q) ^ SIGN_BIT;
		order_gap = best_order_q - order_q[rd] - 32'd1;
		cand = active_q[rd] && !fired_q[rd];
		if (!best_valid_q) begin
			better = 1'b1;
		end else if (key != best_key_q) begin
			better = key < best_key_q;
		end else begin
			better = order_gap < HALF_RANGE;
		end
	end

	// Saturated period and restart periods (zero periodic counts as one).
	always_comb begin
		sat = (in_data.period_value > HALF_RANGE) ? HALF_RANGE[30:0]
			: in_data.period_value[30:0];
		arm_p = (periodic_q[rd] && period_q[rd] == '0) ? 31'd1 : period_q[rd];
		rearm_p = (best_period_q == '0) ? 31'd1 : best_period_q;
	end

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		stat.is_tick = in_data.command == CMD_TICK;
		stat.scan_last = idx_q == IDX_W'(NUM_TIMERS - 1);
		stat.best_expired = best_valid_q && ((tick_now_q - best_dl_q) < HALF_RANGE);
		stat.pending = pend_valid_q;
		stat.out_free = out_free;
	end

	// Timer state and scan registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_now_q <= '0;
			start_counter_q <= '0;
			active_q <= '0;
			periodic_q <= '0;
			fired_q <= '0;
			idx_q <= '0;
			best_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				deadline_q[i] <= '0;
				period_q[i] <= '0;
				order_q[i] <= '0;
			end
		end else begin
			if (cmd.accept) begin
				ack_q.result_kind <= KIND_ACK;
				ack_q.result_timer <= in_data.timer_id;
				ack_q.status <= STATUS_OK;
				ack_q.period_read <= '0;
				ack_q.last_result <= 1'b1;
				unique case (in_data.command)
					CMD_TICK: begin
						tick_now_q <= tick_now_q + 32'd1;
						fired_q <= '0;
						idx_q <= '0;
						best_valid_q <= 1'b0;
						pend_valid_q <= 1'b0;
					end
					CMD_INIT: begin
						period_q[rd] <= sat;
						periodic_q[rd] <= in_data.periodic_mode;
						active_q[rd] <= 1'b0;
						deadline_q[rd] <= '0;
					end
					CMD_START: begin
						deadline_q[rd] <= tick_now_q + {1'b0, arm_p};
						start_counter_q <= start_counter_q + 32'd1;
						order_q[rd] <= start_counter_q + 32'd1;
						active_q[rd] <= 1'b1;
					end
					CMD_STOP: begin
						if (!active_q[rd]) begin
							ack_q.status <= STATUS_ERR;
						end
						active_q[rd] <= 1'b0;
					end
					CMD_GET: begin
						ack_q.period_read <= period_q[rd];
					end
					CMD_SET: begin
						period_q[rd] <= sat;
					end
					CMD_ONESHOT: begin
						periodic_q[rd] <= 1'b0;
					end
					default: begin
						periodic_q[rd] <= 1'b1;
					end
				endcase
			end

			// One slot per cycle against the running best.
			if (cmd.scan_step) begin
				idx_q <= idx_q + IDX_W'(1);
				if (cand && better) begin
					best_valid_q <= 1'b1;
					best_id_q <= rd;
					best_key_q <= key;
					best_dl_q <= deadline_q[rd];
					best_period_q <= period_q[rd];
					best_periodic_q <= periodic_q[rd];
					best_order_q <= order_q[rd];
				end
			end

			// Expire the best slot, restart periodic ones, start a new pass.
			if (cmd.fire) begin
				fired_q[best_id_q] <= 1'b1;
				active_q[best_id_q] <= best_periodic_q;
				if (best_periodic_q) begin
					deadline_q[best_id_q] <= tick_now_q + {1'b0, rearm_p};
					start_counter_q <= start_counter_q + 32'd1;
					order_q[best_id_q] <= start_counter_q + 32'd1;
				end
				pend_valid_q <= 1'b1;
				pend_id_q <= best_id_q;
				idx_q <= '0;
				best_valid_q <= 1'b0;
			end

			if (cmd.finish) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Output register; an expiry is held back one step to mark the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push_ack) begin
				out_valid_q <= 1'b1;
				out_q <= ack_q;
			end else if ((cmd.fire && pend_valid_q) || cmd.finish) begin
				out_valid_q <= 1'b1;
				out_q.result_kind <= KIND_EXPIRED;
				out_q.result_timer <= 4'(pend_id_q);
				out_q.status <= STATUS_OK;
				out_q.period_read <= '0;
				out_q.last_result <= cmd.finish;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

### hdl/ottb_ctrl.sv
// Controller of the ordered timeout timer bank: sequences command beats,
// tick scans and result pushes. Depends on ottb_pkg.
`timescale 1ns / 1ps

module ottb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ottb_pkg::ctl_stat_t stat,
	output ottb_pkg::ctl_cmd_t  cmd
);
	import ottb_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_ACK    = 2'd1;
	localparam logic [1:0] S_SCAN   = 2'd2;
	localparam logic [1:0] S_DECIDE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = stat.is_tick ? S_SCAN : S_ACK;
				end
			end
			S_ACK: begin
				if (stat.out_free) begin
					cmd.push_ack = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = S_DECIDE;
				end
			end
			default: begin
				if (stat.best_expired) begin
					if (!stat.pending || stat.out_free) begin
						cmd.fire = 1'b1;
						state_d = S_SCAN;
					end
				end else if (!stat.pending) begin
					state_d = S_IDLE;
				end else if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### dv/ordered_timeout_timer_bank_unit_tb.sv
// Testbench for the ordered timeout timer bank unit.
// Drives command beats, predicts acknowledge and expiry beats, and checks them in order.
// Depends on ottb_pkg and ordered_timeout_timer_bank_unit.
`timescale 1ns / 1ps

module ordered_timeout_timer_bank_unit_tb;
	import ottb_pkg::*;

	// Predictor of the timer bank plus the queue of beats still due.
	class timer_scoreboard;
		logic [31:0] now_ticks;
		logic [31:0] due_at [NUM_TIMERS];
		logic [30:0] period_of [NUM_TIMERS];
		bit armed [NUM_TIMERS];
		bit repeating [NUM_TIMERS];
		logic [31:0] armed_seq [NUM_TIMERS];
		logic [31:0] arm_count;
		out_beat_t due_beats[$];
		int errors;

		function new();
			now_ticks = '0;
			arm_count = '0;
			errors = 0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				due_at[i] = '0;
				period_of[i] = '0;
				armed[i] = 0;
				repeating[i] = 0;
				armed_seq[i] = '0;
			end
		endfunction

		function logic [30:0] clamp_period(logic [31:0] v);
			return (v > HALF_RANGE) ? HALF_RANGE[30:0] : v[30:0];
		endfunction

		function void arm_timer(int s);
			logic [31:0] p;
			p = {1'b0, period_of[s]};
			if (repeating[s] && p == 0)
				p = 1;
			due_at[s] = now_ticks + p;
			arm_count = arm_count + 1;
			armed_seq[s] = arm_count;
			armed[s] = 1;
		endfunction

		// True when slot a expires ahead of slot b.
		function bit goes_first(int a, int b);
			logic [31:0] ka, kb, d;
			ka = (due_at[a] - now_ticks) ^ SIGN_BIT;
			kb = (due_at[b] - now_ticks) ^ SIGN_BIT;
			if (ka != kb)
				return ka < kb;
			d = armed_seq[b] - armed_seq[a] - 1;
			return d < HALF_RANGE;
		endfunction

		function void push_beat(logic kind, logic [3:0] id, logic st, logic [30:0] per,
				logic last);
			out_beat_t b;
			b.result_kind = kind;
			b.result_timer = id;
			b.status = st;
			b.period_read = per;
			b.last_result = last;
			due_beats.push_back(b);
		endfunction

		// Notes one accepted command beat and queues what it should produce.
		function void note_command(in_beat_t c);
			bit done [NUM_TIMERS];
			int best, n;
			int id;
			id = c.timer_id;
			if (c.command == CMD_TICK) begin
				now_ticks = now_ticks + 1;
				n = 0;
				for (int i = 0; i < NUM_TIMERS; i++)
					done[i] = 0;
				forever begin
					best = -1;
					for (int i = 0; i < NUM_TIMERS; i++)
						if (armed[i] && !done[i] && (best < 0 || goes_first(i, best)))
							best = i;
					if (best < 0)
						break;
					if (now_ticks - due_at[best] >= HALF_RANGE)
						break;
					done[best] = 1;
					armed[best] = 0;
					if (repeating[best])
						arm_timer(best);
					push_beat(KIND_EXPIRED, best[3:0], STATUS_OK, '0, 1'b0);
					n++;
				end
				if (n > 0)
					due_beats[$].last_result = 1'b1;
				return;
			end
			case (c.command)
				CMD_INIT: begin
					period_of[id] = clamp_period(c.period_value);
					repeating[id] = c.periodic_mode;
					armed[id] = 0;
					due_at[id] = '0;
				end
				CMD_START: arm_timer(id);
				CMD_STOP: begin
					if (!armed[id]) begin
						push_beat(KIND_ACK, c.timer_id, STATUS_ERR, '0, 1'b1);
						return;
					end
					armed[id] = 0;
				end
				CMD_GET: begin
					push_beat(KIND_ACK, c.timer_id, STATUS_OK, period_of[id], 1'b1);
					return;
				end
				CMD_SET: period_of[id] = clamp_period(c.period_value);
				CMD_ONESHOT: repeating[id] = 0;
				default: repeating[id] = 1;
			endcase
			push_beat(KIND_ACK, c.timer_id, STATUS_OK, '0, 1'b1);
		endfunction

		// Compares one result beat with the oldest expected beat.
		function void check_beat(out_beat_t got);
			out_beat_t want;
			if (due_beats.size() == 0) begin
				$display("%0t: unexpected beat %h", $time, got);
				errors++;
				return;
			end
			want = due_beats.pop_front();
			if (got.result_kind !== want.result_kind) begin
				$display("%0t: result_kind exp %h got %h", $time, want.result_kind,
					got.result_kind);
				errors++;
			end
			if (got.result_timer !== want.result_timer) begin
				$display("%0t: result_timer exp %h got %h", $time, want.result_timer,
					got.result_timer);
				errors++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status exp %h got %h", $time, want.status, got.status);
				errors++;
			end
			if (got.period_read !== want.period_read) begin
				$display("%0t: period_read exp %h got %h", $time, want.period_read,
					got.period_read);
				errors++;
			end
			if (got.last_result !== want.last_result) begin
				$display("%0t: last_result exp %h got %h", $time, want.last_result,
					got.last_result);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_beat_t in_data;
	logic out_valid;
	logic out_ready;
	out_beat_t out_data;

	timer_scoreboard sb;
	bit quiet_phase;
	bit hold_sink;
	bit stim_done;
	int cycle_count;

	ordered_timeout_timer_bank_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Accepted beats on both channels go to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_command(in_data);
		if (arst_n && out_valid && out_ready)
			sb.check_beat(out_data);
	end

	// Cycle limit for the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 900000) begin
			$display("ordered_timeout_timer_bank_unit_tb: FAIL");
			$finish;
		end
	end

	// Result sink with random stall bursts and one long hold-off.
	initial begin
		int gap;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_sink) begin
				out_ready <= 0;
				repeat (400) @(posedge clk);
				hold_sink = 0;
			end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 18);
				out_ready <= 0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				out_ready <= 1;
			end
		end
	end

	// Sends one command beat and waits for it to be accepted. Valid stays up
	// after acceptance so that a following beat can go out with no gap.
	task automatic send_command(logic [2:0] cmd, logic [3:0] id, logic [31:0] per,
			logic mode);
		in_beat_t b;
		int gap;
		b.command = cmd;
		b.timer_id = id;
		b.period_value = per;
		b.periodic_mode = mode;
		if (!quiet_phase && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 18);
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	// Small periods mostly, so expiries happen; a few extreme ones.
	function automatic logic [31:0] pick_period();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7FFF_FFFF;
			3: return 0;
			default: return $urandom_range(0, 6);
		endcase
	endfunction

	initial begin
		logic [2:0] cmd;
		sb = new();
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		quiet_phase = 0;
		hold_sink = 0;
		stim_done = 0;
		cycle_count = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: empty tick, stop of idle timer, extremes, zero periodic period.
		send_command(CMD_TICK, 4'd0, 32'd0, 1'b0);
		send_command(CMD_STOP, 4'd15, 32'd0, 1'b0);
		send_command(CMD_INIT, 4'd0, 32'hFFFF_FFFF, 1'b1);
		send_command(CMD_GET, 4'd0, 32'd0, 1'b0);
		send_command(CMD_INIT, 4'd15, 32'd0, 1'b1);
		send_command(CMD_INIT, 4'd1, 32'd0, 1'b0);
		send_command(CMD_INIT, 4'd2, 32'd2, 1'b0);
		send_command(CMD_START, 4'd15, 32'd0, 1'b0);
		send_command(CMD_START, 4'd1, 32'd0, 1'b0);
		send_command(CMD_START, 4'd2, 32'd0, 1'b0);
		send_command(CMD_TICK, 4'd0, 32'd0, 1'b0);
		send_command(CMD_TICK, 4'd0, 32'd0, 1'b0);
		send_command(CMD_SET, 4'd2, 32'h8000_0000, 1'b0);
		send_command(CMD_GET, 4'd2, 32'd0, 1'b0);
		send_command(CMD_PERIODIC, 4'd2, 32'd0, 1'b0);
		send_command(CMD_ONESHOT, 4'd15, 32'd0, 1'b0);
		send_command(CMD_STOP, 4'd15, 32'd0, 1'b0);
		send_command(CMD_START, 4'd0, 32'd0, 1'b0);
		send_command(CMD_INIT, 4'd0, 32'd5, 1'b1);
		send_command(CMD_TICK, 4'd0, 32'd0, 1'b0);
		send_command(CMD_STOP, 4'd1, 32'd0, 1'b0);

		// Random part; the sink holds off once while commands keep coming.
		for (int k = 0; k < 380; k++) begin
			if (k == 120)
				hold_sink = 1;
			if (k == 330)
				quiet_phase = 1;
			cmd = ($urandom_range(0, 3) == 0) ? CMD_TICK : 3'($urandom_range(1, 7));
			send_command(cmd, 4'($urandom_range(0, 15)), pick_period(),
				1'($urandom_range(0, 1)));
		end
		in_valid <= 0;
		stim_done = 1;

		while (sb.due_beats.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.due_beats.size() == 0)
			$display("ordered_timeout_timer_bank_unit_tb: PASS");
		else
			$display("ordered_timeout_timer_bank_unit_tb: FAIL");
		$finish;
	end

endmodule

### filelist.f
hdl/ottb_pkg.sv
hdl/ottb_datapath.sv
hdl/ottb_ctrl.sv
hdl/ordered_timeout_timer_bank_unit.sv
dv/ordered_timeout_timer_bank_unit_tb.sv
